>>> rtl/bmtg_pkg.sv
// Bitboard move target generator: shared types, direction tables and shift helpers.
// Used by every module of the block; depends on nothing.
package bmtg_pkg;

   // Piece kinds
   typedef enum logic [2:0] {
      FUNC_PAWN   = 3'd0,
      FUNC_KNIGHT = 3'd1,
      FUNC_BISHOP = 3'd2,
      FUNC_ROOK   = 3'd3,
      FUNC_QUEEN  = 3'd4,
      FUNC_KING   = 3'd5
   } func_type;

   localparam int NUM_DIRS   = 8;
   localparam int NUM_LEVELS = 3;

   // Ray directions, index into the tables below
   localparam int DIR_N  = 0;
   localparam int DIR_S  = 1;
   localparam int DIR_E  = 2;
   localparam int DIR_W  = 3;
   localparam int DIR_NE = 4;
   localparam int DIR_SE = 5;
   localparam int DIR_NW = 6;
   localparam int DIR_SW = 7;

   localparam logic [63:0] NOT_A_FILE = 64'hfefe_fefe_fefe_fefe;
   localparam logic [63:0] NOT_H_FILE = 64'h7f7f_7f7f_7f7f_7f7f;
   localparam logic [63:0] ALL_SQ     = 64'hffff_ffff_ffff_ffff;
   localparam logic [63:0] RANK_1     = 64'h0000_0000_0000_00ff;
   localparam logic [63:0] RANK_3     = 64'h0000_0000_00ff_0000;
   localparam logic [63:0] RANK_6     = 64'h0000_ff00_0000_0000;
   localparam logic [63:0] RANK_8     = 64'hff00_0000_0000_0000;

   // Toward higher square numbers (bit set) or lower
   localparam logic [NUM_DIRS-1:0] DIR_UP = 8'b0101_0101;
   localparam int DIR_STEP [NUM_DIRS] = '{8, 8, 1, 1, 9, 7, 7, 9};
   localparam logic [63:0] DIR_MASK [NUM_DIRS] = '{
      ALL_SQ, ALL_SQ, NOT_A_FILE, NOT_H_FILE,
      NOT_A_FILE, NOT_A_FILE, NOT_H_FILE, NOT_H_FILE
   };

   // Word passed from stage to stage
   typedef struct packed {
      logic                            valid;
      logic [2:0]                      func;
      logic [63:0]                     own;
      logic [63:0]                     kind;
      logic [63:0]                     simple_targets;
      logic [63:0]                     simple_promo;
      logic [NUM_DIRS-1:0][63:0]       gen;
      logic [NUM_DIRS-1:0][63:0]       prop;
   } stage_type;

   // One square step in direction dir, with wrap masking
   function automatic logic [63:0] go_dir(input logic [63:0] b, input int dir);
      logic [63:0] shifted;
      shifted = DIR_UP[dir] ? (b << DIR_STEP[dir]) : (b >> DIR_STEP[dir]);
      return shifted & DIR_MASK[dir];
   endfunction

   // Kogge-Stone shift for one fill level (distance step << level)
   function automatic logic [63:0] fill_shift(input logic [63:0] b, input int dir,
                                              input int level);
      int span;
      span = DIR_STEP[dir] << level;
      return DIR_UP[dir] ? (b << span) : (b >> span);
   endfunction

endpackage

>>> rtl/bmtg_decode.sv
// Front stage: side selection, occupancy, and the pawn, knight and king targets.
// Depends on bmtg_pkg.
module bmtg_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [2:0]            func,
   input  logic                  side,
   input  logic [63:0]           kind_board,
   input  logic [63:0]           white_board,
   input  logic [63:0]           black_board,
   output bmtg_pkg::stage_type   stage_o
);

   bmtg_pkg::stage_type stage_in, stage_ff;

   logic [63:0] own, enemy, occ, empty, mine;
   logic [63:0] pawn_caps, pawn_push, pawn_dbl, pawn_all;
   logic [63:0] knight_t, king_t;

   // Side view of the boards
   always_comb begin
      own   = side ? black_board : white_board;
      enemy = side ? white_board : black_board;
      occ   = white_board | black_board;
      empty = ~occ;
      mine  = kind_board & own;
   end

   // Pawn pushes and captures
   always_comb begin
      if (!side) begin
         pawn_caps = (bmtg_pkg::go_dir(mine, bmtg_pkg::DIR_NE) |
                      bmtg_pkg::go_dir(mine, bmtg_pkg::DIR_NW)) & enemy;
         pawn_push = bmtg_pkg::go_dir(mine, bmtg_pkg::DIR_N) & ~occ;
         pawn_dbl  = pawn_push & bmtg_pkg::RANK_3;
         pawn_push = pawn_push | (bmtg_pkg::go_dir(pawn_dbl, bmtg_pkg::DIR_N) & ~occ);
      end else begin
         pawn_caps = (bmtg_pkg::go_dir(mine, bmtg_pkg::DIR_SE) |
                      bmtg_pkg::go_dir(mine, bmtg_pkg::DIR_SW)) & enemy;
         pawn_push = bmtg_pkg::go_dir(mine, bmtg_pkg::DIR_S) & ~occ;
         pawn_dbl  = pawn_push & bmtg_pkg::RANK_6;
         pawn_push = pawn_push | (bmtg_pkg::go_dir(pawn_dbl, bmtg_pkg::DIR_S) & ~occ);
      end
      pawn_all = pawn_caps | pawn_push;
   end

   // Knight and king leapers
   always_comb begin
      knight_t =
         bmtg_pkg::go_dir(bmtg_pkg::go_dir(mine, bmtg_pkg::DIR_W), bmtg_pkg::DIR_NW) |
         bmtg_pkg::go_dir(bmtg_pkg::go_dir(mine, bmtg_pkg::DIR_N), bmtg_pkg::DIR_NW) |
         bmtg_pkg::go_dir(bmtg_pkg::go_dir(mine, bmtg_pkg::DIR_N), bmtg_pkg::DIR_NE) |
         bmtg_pkg::go_dir(bmtg_pkg::go_dir(mine, bmtg_pkg::DIR_E), bmtg_pkg::DIR_NE) |
         bmtg_pkg::go_dir(bmtg_pkg::go_dir(mine, bmtg_pkg::DIR_E), bmtg_pkg::DIR_SE) |
         bmtg_pkg::go_dir(bmtg_pkg::go_dir(mine, bmtg_pkg::DIR_S), bmtg_pkg::DIR_SE) |
         bmtg_pkg::go_dir(bmtg_pkg::go_dir(mine, bmtg_pkg::DIR_S), bmtg_pkg::DIR_SW) |
         bmtg_pkg::go_dir(bmtg_pkg::go_dir(mine, bmtg_pkg::DIR_W), bmtg_pkg::DIR_SW);
      king_t = '0;
      for (int d = 0; d < bmtg_pkg::NUM_DIRS; d++) begin
         king_t = king_t | bmtg_pkg::go_dir(mine, d);
      end
   end

   // Assemble the stage word
   always_comb begin
      stage_in.valid = accept;
      stage_in.func  = func;
      stage_in.own   = own;
      stage_in.kind  = kind_board;
      case (func)
         bmtg_pkg::FUNC_PAWN: begin
            stage_in.simple_promo   = pawn_all & (bmtg_pkg::RANK_1 | bmtg_pkg::RANK_8);
            stage_in.simple_targets = pawn_all & ~(bmtg_pkg::RANK_1 | bmtg_pkg::RANK_8);
         end
         bmtg_pkg::FUNC_KNIGHT: begin
            stage_in.simple_promo   = '0;
            stage_in.simple_targets = knight_t & ~own;
         end
         bmtg_pkg::FUNC_KING: begin
            stage_in.simple_promo   = '0;
            stage_in.simple_targets = king_t & ~own;
         end
         default: begin
            stage_in.simple_promo   = '0;
            stage_in.simple_targets = '0;
         end
      endcase
      for (int d = 0; d < bmtg_pkg::NUM_DIRS; d++) begin
         stage_in.gen[d]  = mine;
         stage_in.prop[d] = empty & bmtg_pkg::DIR_MASK[d];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

>>> rtl/bmtg_fill.sv
// Three registered Kogge-Stone occluded fill levels over all eight ray directions.
// Depends on bmtg_pkg.
module bmtg_fill (
   input  logic                  clock,
   input  logic                  reset,
   input  bmtg_pkg::stage_type   stage_i,
   output bmtg_pkg::stage_type   stage_o
);

   bmtg_pkg::stage_type level_in [bmtg_pkg::NUM_LEVELS];
   bmtg_pkg::stage_type level_ff [bmtg_pkg::NUM_LEVELS];

   // One doubling step per level: generator grows through propagator
   always_comb begin
      bmtg_pkg::stage_type src;
      for (int k = 0; k < bmtg_pkg::NUM_LEVELS; k++) begin
         src = (k == 0) ? stage_i : level_ff[(k == 0) ? 0 : k - 1];
         level_in[k] = src;
         for (int d = 0; d < bmtg_pkg::NUM_DIRS; d++) begin
            level_in[k].gen[d]  = src.gen[d] |
                                  (src.prop[d] & bmtg_pkg::fill_shift(src.gen[d], d, k));
            level_in[k].prop[d] = src.prop[d] & bmtg_pkg::fill_shift(src.prop[d], d, k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < bmtg_pkg::NUM_LEVELS; k++) begin
            level_ff[k].valid <= 1'b0;
         end
      end else begin
         level_ff <= level_in;
      end
   end

   assign stage_o = level_ff[bmtg_pkg::NUM_LEVELS-1];

endmodule

>>> rtl/bmtg_result.sv
// Back stage: slider hits and per-kind result select into the output register.
// Depends on bmtg_pkg.
module bmtg_result (
   input  logic                  clock,
   input  logic                  reset,
   input  bmtg_pkg::stage_type   stage_i,
   output logic                  rsp_valid,
   output logic [63:0]           rsp_targets,
   output logic [63:0]           rsp_promotion_targets
);

   logic        valid_ff;
   logic [63:0] targets_in, targets_ff;
   logic [63:0] promo_in, promo_ff;
   logic [63:0] diag_fill, diag_hit, line_fill, line_hit;
   logic [63:0] diag_t, line_t;

   // Ray fills plus the first blocker beyond each ray
   always_comb begin
      diag_fill = stage_i.gen[bmtg_pkg::DIR_NE] | stage_i.gen[bmtg_pkg::DIR_SE] |
                  stage_i.gen[bmtg_pkg::DIR_NW] | stage_i.gen[bmtg_pkg::DIR_SW];
      line_fill = stage_i.gen[bmtg_pkg::DIR_N] | stage_i.gen[bmtg_pkg::DIR_S] |
                  stage_i.gen[bmtg_pkg::DIR_E] | stage_i.gen[bmtg_pkg::DIR_W];
      diag_hit  = bmtg_pkg::go_dir(stage_i.gen[bmtg_pkg::DIR_NE], bmtg_pkg::DIR_NE) |
                  bmtg_pkg::go_dir(stage_i.gen[bmtg_pkg::DIR_SE], bmtg_pkg::DIR_SE) |
                  bmtg_pkg::go_dir(stage_i.gen[bmtg_pkg::DIR_NW], bmtg_pkg::DIR_NW) |
                  bmtg_pkg::go_dir(stage_i.gen[bmtg_pkg::DIR_SW], bmtg_pkg::DIR_SW);
      line_hit  = bmtg_pkg::go_dir(stage_i.gen[bmtg_pkg::DIR_N], bmtg_pkg::DIR_N) |
                  bmtg_pkg::go_dir(stage_i.gen[bmtg_pkg::DIR_S], bmtg_pkg::DIR_S) |
                  bmtg_pkg::go_dir(stage_i.gen[bmtg_pkg::DIR_E], bmtg_pkg::DIR_E) |
                  bmtg_pkg::go_dir(stage_i.gen[bmtg_pkg::DIR_W], bmtg_pkg::DIR_W);
      diag_t = (diag_fill & ~stage_i.kind) | (diag_hit & ~stage_i.own);
      line_t = (line_fill & ~stage_i.kind) | (line_hit & ~stage_i.own);
   end

   // Select by piece kind
   always_comb begin
      promo_in = '0;
      case (stage_i.func)
         bmtg_pkg::FUNC_PAWN: begin
            targets_in = stage_i.simple_targets;
            promo_in   = stage_i.simple_promo;
         end
         bmtg_pkg::FUNC_KNIGHT: targets_in = stage_i.simple_targets;
         bmtg_pkg::FUNC_KING:   targets_in = stage_i.simple_targets;
         bmtg_pkg::FUNC_BISHOP: targets_in = diag_t;
         bmtg_pkg::FUNC_ROOK:   targets_in = line_t;
         bmtg_pkg::FUNC_QUEEN:  targets_in = diag_t | line_t;
         default:               targets_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      targets_ff <= targets_in;
      promo_ff   <= promo_in;
   end

   assign rsp_valid             = valid_ff;
   assign rsp_targets           = targets_ff;
   assign rsp_promotion_targets = promo_ff;

endmodule

>>> rtl/bitboard_move_target_generator.sv
// Bitboard move target generator, top level.
// Depends on bmtg_pkg, bmtg_decode, bmtg_fill and bmtg_result.
//
// Usage:
//   A request word (req_func, req_side and the kind, white and black boards) is
//   taken at each rising edge with start high; busy is always low, so a new
//   word may be issued every cycle.
//   Each request yields one response word: rsp_targets and
//   rsp_promotion_targets, marked by a one-cycle rsp_valid strobe.
//   Each word passes the decode stage, the three fill levels and the result
//   register in turn and reaches the rsp_ ports in request order.
//   Throughput: one word per cycle, set by the five-stage pipeline; each fill
//   level of all eight rays sits in a register stage of its own.
//   Reset (synchronous, active high) clears the valid bits of every stage;
//   words in flight are dropped and no response appears until new requests.
//   The receiver has no back-pressure: a response must be taken in the cycle
//   in which rsp_valid is high.
module bitboard_move_target_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic        req_side,
   input  logic [63:0] req_kind_board,
   input  logic [63:0] req_white_board,
   input  logic [63:0] req_black_board,
   output logic        rsp_valid,
   output logic [63:0] rsp_targets,
   output logic [63:0] rsp_promotion_targets
);

   bmtg_pkg::stage_type decode_stage, fill_stage;
   logic                accept;

   // Pipeline never stalls
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   bmtg_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .func        (req_func),
      .side        (req_side),
      .kind_board  (req_kind_board),
      .white_board (req_white_board),
      .black_board (req_black_board),
      .stage_o     (decode_stage)
   );

   bmtg_fill u_fill (
      .clock   (clock),
      .reset   (reset),
      .stage_i (decode_stage),
      .stage_o (fill_stage)
   );

   bmtg_result u_result (
      .clock                 (clock),
      .reset                 (reset),
      .stage_i               (fill_stage),
      .rsp_valid             (rsp_valid),
      .rsp_targets           (rsp_targets),
      .rsp_promotion_targets (rsp_promotion_targets)
   );

endmodule
